/* hdl/event_window_pixel_histogram_core_macros.svh */
// Assertion macros for the event window pixel histogram core.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef EVENT_WINDOW_PIXEL_HISTOGRAM_CORE_MACROS_SVH
`define EVENT_WINDOW_PIXEL_HISTOGRAM_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define EWPH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define EWPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ewph_pkg.sv */
// Shared types and constants of the event window pixel histogram core.
// No dependencies; imported by the controller, the datapath and the top level.
package ewph_pkg;

  // Field widths of one event and of one count
  localparam int unsigned COORD_W = 9;
  localparam int unsigned COUNT_W = 15;
  localparam int unsigned WIN_W   = 15;
  localparam int unsigned FRAME_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  // Command codes carried on in_tuser
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Status codes carried on out_tuser
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [WIN_W-1:0]   WINDOW_RESET = 15'd10000;
  localparam logic [FRAME_W-1:0] WIDTH_RESET  = 10'd346;
  localparam logic [FRAME_W-1:0] HEIGHT_RESET = 10'd260;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

  // One event as held in the window FIFO and as packed in in_tdata
  typedef struct packed {
    logic               pol;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } ev_entry_t;

  localparam int unsigned EV_W = $bits(ev_entry_t);

  // One word of the count memory
  typedef struct packed {
    logic [COUNT_W-1:0] neg;
    logic [COUNT_W-1:0] pos;
  } cnt_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the incoming transaction
    logic fifo_rd;    // read the oldest FIFO entry
    logic old_rd;     // read counts at the evicted pixel
    logic old_wr;     // write back the decremented counts, retire the oldest entry
    logic new_rd;     // read counts at the item's pixel
    logic upd_wr;     // write incremented counts and push the event
    logic load_out;   // load the result register
    logic clr_start;  // restart the clearing sweep
    logic clr_wr;     // clear one count word
  } ewph_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_oof;      // incoming item lies outside the frame
    logic in_push;     // incoming item is a push
    logic evict;       // window is full, a push must evict first
    logic oof_r;       // held item lies outside the frame
    logic push_r;      // held item is a push
    logic clr_last;    // sweep sits on the last count word
    logic win_rewrite; // window size written this cycle
  } ewph_sts_t;

endpackage

/* hdl/event_window_pixel_histogram_core.sv */
// Sliding-window event counter for an event camera. The core keeps the last
// window_events events in a FIFO and, per pixel, the number of positive and negative
// events among them. A push (tuser 0) evicts the oldest event when the window is full,
// adds the new one and returns the updated counts at its pixel; a read (tuser 1)
// returns the counts unchanged. Coordinates outside the frame return zero counts with
// status 1 and change nothing. One item is in work at a time: an out-of-frame item goes
// straight to the update, others first read their pixel's counts, and a push that
// evicts first reads and decrements the oldest event's counts; the update waits for a
// free result register. After reset and every write of window_events the count memory
// is swept clear, one word a cycle, over 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) words
// (262144 at the default sizes); no item is accepted during the sweep.
// Depends on ewph_pkg, ewph_ctrl, ewph_datapath and the assertion macro header.
`include "event_window_pixel_histogram_core_macros.svh"

module event_window_pixel_histogram_core
  import ewph_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16384,
  parameter int unsigned MAX_WIDTH    = 512,
  parameter int unsigned MAX_HEIGHT   = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input transactions
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pixel_x[8:0], pixel_y[17:9], polarity[18]
  input  logic                   in_tuser,   // command[0]
  // result transactions
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // positive_count[14:0], negative_count[29:15]
  output logic                   out_tuser   // status[0]
);

  ewph_cmd_t ctl_cmd;
  ewph_sts_t dp_sts;

  // Sequencing
  ewph_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (dp_sts),
    .cmd        (ctl_cmd)
  );

  // Storage and arithmetic
  ewph_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (ctl_cmd),
    .sts       (dp_sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Only one item in work at a time
  `EWPH_ASSERT_NEXT(a_single_item, in_tvalid && in_tready, !in_tready, "input taken while an item is in work")
  // A result appears only after the result register was loaded
  `EWPH_ASSERT_SAME(a_result_loaded, $rose(out_tvalid), $past(ctl_cmd.load_out), "result valid without a load")
  // The clearing sweep owns the count memory and blocks input
  `EWPH_ASSERT_SAME(a_clear_exclusive, ctl_cmd.clr_wr, !in_tready && !ctl_cmd.upd_wr && !ctl_cmd.old_wr, "count write or accept during clearing")

endmodule

/* hdl/ewph_ctrl.sv */
// Controller state machine of the event window pixel histogram core.
// Depends on ewph_pkg; drives the datapath through ewph_cmd_t.
module ewph_ctrl
  import ewph_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  ewph_sts_t sts,
  output ewph_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_OLD_FETCH = 3'd2;
  localparam logic [2:0] ST_OLD_RD    = 3'd3;
  localparam logic [2:0] ST_OLD_WR    = 3'd4;
  localparam logic [2:0] ST_NEW_RD    = 3'd5;
  localparam logic [2:0] ST_UPDATE    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  // Sequence one item at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    if (sts.win_rewrite) begin
      cmd.clr_start = 1'b1;
      state_nxt     = ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          cmd.clr_wr = 1'b1;
          if (sts.clr_last) begin
            state_nxt = ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd.capture = 1'b1;
            if (sts.in_oof) begin
              state_nxt = ST_UPDATE;
            end else if (sts.in_push && sts.evict) begin
              state_nxt = ST_OLD_FETCH;
            end else begin
              state_nxt = ST_NEW_RD;
            end
          end
        end
        ST_OLD_FETCH: begin
          cmd.fifo_rd = 1'b1;
          state_nxt   = ST_OLD_RD;
        end
        ST_OLD_RD: begin
          cmd.old_rd = 1'b1;
          state_nxt  = ST_OLD_WR;
        end
        ST_OLD_WR: begin
          cmd.old_wr = 1'b1;
          state_nxt  = ST_NEW_RD;
        end
        ST_NEW_RD: begin
          cmd.new_rd = 1'b1;
          state_nxt  = ST_UPDATE;
        end
        ST_UPDATE: begin
          // Hold until the result register is free
          if (out_free) begin
            cmd.load_out = 1'b1;
            cmd.upd_wr   = sts.push_r && !sts.oof_r;
            state_nxt    = ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_CLEAR;
        end
      endcase
    end
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/ewph_datapath.sv */
// Datapath of the event window pixel histogram core: configuration registers,
// event FIFO memory, per-pixel count memory and result register. Depends on ewph_pkg.
module ewph_datapath
  import ewph_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16384,
  parameter int unsigned MAX_WIDTH    = 512,
  parameter int unsigned MAX_HEIGHT   = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  ewph_cmd_t              cmd,
  output ewph_sts_t              sts,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  localparam int unsigned XW        = $clog2(MAX_WIDTH);
  localparam int unsigned YW        = $clog2(MAX_HEIGHT);
  localparam int unsigned AW        = XW + YW;
  localparam int unsigned CNT_DEPTH = 1 << AW;
  localparam int unsigned PW        = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW        = $clog2(WINDOW_DEPTH + 1);

  // Pixel address: row bits over column bits, one word per pixel
  function automatic logic [AW-1:0] pix_addr(input ev_entry_t ev);
    pix_addr = {YW'(ev.y), XW'(ev.x)};
  endfunction

  logic [WIN_W-1:0]   win_r;
  logic [FRAME_W-1:0] width_r;
  logic [FRAME_W-1:0] height_r;

  ev_entry_t          in_ev;
  ev_entry_t          item_r;
  logic               push_r;
  logic               oof_r;
  logic               in_oof;

  ev_entry_t          fifo_mem [WINDOW_DEPTH];
  ev_entry_t          fifo_q_r;
  logic [PW-1:0]      head_r;
  logic [FW-1:0]      fill_r;
  logic [31:0]        win_eff;
  logic [31:0]        slot_sum;
  logic [PW-1:0]      slot;

  cnt_word_t          cnt_mem [CNT_DEPTH];
  cnt_word_t          cnt_q_r;
  cnt_word_t          dec_word;
  cnt_word_t          inc_word;
  cnt_word_t          wr_word;
  logic [AW-1:0]      old_addr;
  logic [AW-1:0]      new_addr;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               cnt_we;
  logic [AW-1:0]      clr_addr_r;
  logic               win_rewrite;

  logic [COUNT_W-1:0] out_pos_r;
  logic [COUNT_W-1:0] out_neg_r;
  logic               out_status_r;

  // Configuration registers
  assign win_rewrite = cfg_wr_en && (cfg_index == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= WINDOW_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WINDOW: win_r    <= WIN_W'(cfg_data);
        REG_WIDTH:  width_r  <= FRAME_W'(cfg_data);
        REG_HEIGHT: height_r <= FRAME_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Bound check of the incoming item
  assign in_ev  = ev_entry_t'(in_tdata[EV_W-1:0]);
  assign in_oof = ({1'b0, in_ev.x} >= width_r) || ({1'b0, in_ev.y} >= height_r) ||
                  (32'(in_ev.x) >= 32'(MAX_WIDTH)) || (32'(in_ev.y) >= 32'(MAX_HEIGHT));

  // Hold the item in work
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_ev;
      push_r <= (in_tuser == CMD_PUSH);
      oof_r  <= in_oof;
    end
  end

  // Window size: zero acts as one, saturate at the FIFO depth
  always_comb begin
    if (win_r == '0) begin
      win_eff = 32'd1;
    end else if (32'(win_r) > 32'(WINDOW_DEPTH)) begin
      win_eff = 32'(WINDOW_DEPTH);
    end else begin
      win_eff = 32'(win_r);
    end
  end

  // Free slot sits fill entries past the head, before and after an eviction alike
  assign slot_sum = 32'(head_r) + 32'(fill_r);
  assign slot     = (slot_sum >= 32'(WINDOW_DEPTH)) ? PW'(slot_sum - 32'(WINDOW_DEPTH))
                                                    : PW'(slot_sum);

  // Event FIFO memory
  always_ff @(posedge clk) begin
    if (cmd.fifo_rd) begin
      fifo_q_r <= fifo_mem[head_r];
    end
    if (cmd.upd_wr) begin
      fifo_mem[slot] <= item_r;
    end
  end

  // FIFO pointers: retire on eviction, grow on push, empty on window rewrite
  always_ff @(posedge clk) begin
    if (!rst_n || win_rewrite) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (cmd.old_wr) begin
      head_r <= (head_r == PW'(WINDOW_DEPTH - 1)) ? '0 : head_r + PW'(1);
      fill_r <= fill_r - FW'(1);
    end else if (cmd.upd_wr) begin
      fill_r <= fill_r + FW'(1);
    end
  end

  // Count updates: decrement the evicted event, saturate the new one
  assign old_addr = pix_addr(fifo_q_r);
  assign new_addr = pix_addr(item_r);

  always_comb begin
    dec_word = cnt_q_r;
    if (fifo_q_r.pol) begin
      if (cnt_q_r.pos != '0) dec_word.pos = cnt_q_r.pos - COUNT_W'(1);
    end else begin
      if (cnt_q_r.neg != '0) dec_word.neg = cnt_q_r.neg - COUNT_W'(1);
    end
  end

  always_comb begin
    inc_word = cnt_q_r;
    if (item_r.pol) begin
      if (cnt_q_r.pos != COUNT_MAX) inc_word.pos = cnt_q_r.pos + COUNT_W'(1);
    end else begin
      if (cnt_q_r.neg != COUNT_MAX) inc_word.neg = cnt_q_r.neg + COUNT_W'(1);
    end
  end

  // Count memory ports
  assign rd_addr = cmd.old_rd ? old_addr : new_addr;

  always_comb begin
    cnt_we  = 1'b1;
    wr_addr = new_addr;
    wr_word = inc_word;
    priority if (cmd.clr_wr) begin
      wr_addr = clr_addr_r;
      wr_word = '0;
    end else if (cmd.old_wr) begin
      wr_addr = old_addr;
      wr_word = dec_word;
    end else if (cmd.upd_wr) begin
      wr_addr = new_addr;
      wr_word = inc_word;
    end else begin
      cnt_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.old_rd || cmd.new_rd) begin
      cnt_q_r <= cnt_mem[rd_addr];
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_word;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_start) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (oof_r) begin
        out_pos_r    <= '0;
        out_neg_r    <= '0;
        out_status_r <= STATUS_OUTSIDE;
      end else if (push_r) begin
        out_pos_r    <= inc_word.pos;
        out_neg_r    <= inc_word.neg;
        out_status_r <= STATUS_OK;
      end else begin
        out_pos_r    <= cnt_q_r.pos;
        out_neg_r    <= cnt_q_r.neg;
        out_status_r <= STATUS_OK;
      end
    end
  end

  assign out_tdata = {(OUT_TDATA_W - 2 * COUNT_W)'(0), out_neg_r, out_pos_r};
  assign out_tuser = out_status_r;

  // Status to the controller
  assign sts.in_oof      = in_oof;
  assign sts.in_push     = (in_tuser == CMD_PUSH);
  assign sts.evict       = (32'(fill_r) >= win_eff);
  assign sts.oof_r       = oof_r;
  assign sts.push_r      = push_r;
  assign sts.clr_last    = (clr_addr_r == {AW{1'b1}});
  assign sts.win_rewrite = win_rewrite;

endmodule

/* tb/sv/tb_event_window_pixel_histogram_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for event_window_pixel_histogram_core: streams push and read
// transactions, predicts the per-pixel window counts and checks every result in order.
// Depends on ewph_pkg and the core RTL with its macro header; needs no other file.
module tb_event_window_pixel_histogram_core;
  import ewph_pkg::*;

  localparam int unsigned WINDOW_DEPTH = 16384;
  localparam int unsigned MAX_WIDTH    = 512;
  // Longest quiet stretch is one count-memory sweep over 262144 words, well under the limit
  localparam int unsigned WATCHDOG_LIMIT  = 1100000;
  localparam int unsigned RX_STALL_CYCLES = 500;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic      cmd;
    ev_entry_t ev;
  } hist_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] neg;
    logic               status;
  } count_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  event_window_pixel_histogram_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shared between stimulus, driver and monitor
  hist_item_t    pending_events[$];
  count_result_t expected_counts[$];
  hist_item_t    offered_event;
  count_result_t observed, predicted;
  int unsigned   items_queued   = 0;
  int unsigned   items_accepted = 0;
  int unsigned   results_seen   = 0;
  int unsigned   mismatches     = 0;
  int unsigned   idle_pct       = 18;
  int unsigned   rx_stall_left  = 0;
  int unsigned   quiet_cycles   = 0;

  // Predictor copy of the registers, the window and the count stores
  logic [WIN_W-1:0]   win_size_reg = WINDOW_RESET;
  logic [FRAME_W-1:0] width_reg    = WIDTH_RESET;
  logic [FRAME_W-1:0] height_reg   = HEIGHT_RESET;
  ev_entry_t          win_events[$];
  bit [COUNT_W-1:0]   pos_hist[int unsigned];
  bit [COUNT_W-1:0]   neg_hist[int unsigned];

  // Create zero entries for a pixel not yet counted
  function automatic void touch_pixel(input int unsigned addr);
    if (!pos_hist.exists(addr)) pos_hist[addr] = '0;
    if (!neg_hist.exists(addr)) neg_hist[addr] = '0;
  endfunction

  // Apply one item to the window and return the counts it reports
  function automatic count_result_t histogram_predict(input hist_item_t item);
    count_result_t res;
    ev_entry_t     oldest;
    int unsigned   addr, old_addr, win_eff;
    res = '0;
    if (32'(item.ev.x) >= 32'(width_reg) || 32'(item.ev.y) >= 32'(height_reg)) begin
      res.status = STATUS_OUTSIDE;
      return res;
    end
    addr = 32'(item.ev.y) * MAX_WIDTH + 32'(item.ev.x);
    touch_pixel(addr);
    if (item.cmd == CMD_PUSH) begin
      if (win_size_reg == '0) win_eff = 1;
      else if (32'(win_size_reg) > WINDOW_DEPTH) win_eff = WINDOW_DEPTH;
      else win_eff = 32'(win_size_reg);
      // Evict the oldest event first, even if it now lies outside the frame
      if (win_events.size() >= win_eff) begin
        oldest   = win_events[0];
        win_events.delete(0);
        old_addr = 32'(oldest.y) * MAX_WIDTH + 32'(oldest.x);
        touch_pixel(old_addr);
        if (oldest.pol) begin
          if (pos_hist[old_addr] != '0) pos_hist[old_addr] = pos_hist[old_addr] - COUNT_W'(1);
        end else begin
          if (neg_hist[old_addr] != '0) neg_hist[old_addr] = neg_hist[old_addr] - COUNT_W'(1);
        end
      end
      win_events.insert(win_events.size(), item.ev);
      if (item.ev.pol) begin
        if (pos_hist[addr] != COUNT_MAX) pos_hist[addr] = pos_hist[addr] + COUNT_W'(1);
      end else begin
        if (neg_hist[addr] != COUNT_MAX) neg_hist[addr] = neg_hist[addr] + COUNT_W'(1);
      end
    end
    res.pos    = pos_hist[addr];
    res.neg    = neg_hist[addr];
    res.status = STATUS_OK;
    return res;
  endfunction

  // Write one register and mirror it in the predictor; only called while idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_WINDOW: begin
        win_size_reg = data[WIN_W-1:0];
        win_events.delete();
        pos_hist.delete();
        neg_hist.delete();
      end
      REG_WIDTH:  width_reg  = data[FRAME_W-1:0];
      REG_HEIGHT: height_reg = data[FRAME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_event(input logic cmd, input int unsigned x, y, input logic pol);
    hist_item_t item;
    item.cmd    = cmd;
    item.ev.x   = x[COORD_W-1:0];
    item.ev.y   = y[COORD_W-1:0];
    item.ev.pol = pol;
    pending_events.insert(pending_events.size(), item);
    items_queued++;
  endtask

  // Mostly pushes around a hot spot so counts build up, the rest anywhere in the field range
  task automatic queue_random(input int unsigned count, input int unsigned hot_x, hot_y);
    int unsigned x, y;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) begin
        x = hot_x + $urandom_range(3);
        y = hot_y + $urandom_range(2);
      end else begin
        x = $urandom_range(511);
        y = $urandom_range(511);
      end
      queue_event(($urandom_range(99) < 30) ? CMD_READ : CMD_PUSH, x, y,
                  1'($urandom_range(1)));
    end
  endtask

  // Hold the sender until every queued item is accepted and answered
  task automatic wait_drained();
    while (items_accepted != items_queued || expected_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Driver: feed pending items onto the input channel
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // Record the accepted transaction in the predictor
      if (in_tvalid && in_tready) begin
        expected_counts.insert(expected_counts.size(), histogram_predict(offered_event));
        items_accepted++;
      end
      // Offer the next item, or hold the current one until it is taken
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offered_event = pending_events[0];
          pending_events.delete(0);
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'(offered_event.ev);
          in_tuser  <= offered_event.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        observed.pos    = out_tdata[COUNT_W-1:0];
        observed.neg    = out_tdata[2*COUNT_W-1:COUNT_W];
        observed.status = out_tuser;
        if (expected_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: pos %0d neg %0d status %0b",
                     observed.pos, observed.neg, observed.status);
        end else begin
          predicted = expected_counts[0];
          expected_counts.delete(0);
          if (observed !== predicted) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected pos %0d neg %0d status %0b, got pos %0d neg %0d status %0b",
                       results_seen, predicted.pos, predicted.neg, predicted.status,
                       observed.pos, observed.neg, observed.status);
          end
        end
        results_seen++;
        // Back off for a long stretch so the core fills up and stalls its input
        if (results_seen == 200 || results_seen == 450) rx_stall_left = RX_STALL_CYCLES;
      end
      if (rx_stall_left != 0) begin
        rx_stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("event_window_pixel_histogram_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned w, h;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: frame bounds, outside-frame items, reads of fresh pixels
    queue_event(CMD_PUSH, 0, 0, 1'b1);
    queue_event(CMD_PUSH, 0, 0, 1'b0);
    queue_event(CMD_PUSH, 0, 0, 1'b1);
    queue_event(CMD_READ, 0, 0, 1'b0);
    queue_event(CMD_PUSH, 345, 259, 1'b1);
    queue_event(CMD_READ, 345, 259, 1'b1);
    queue_event(CMD_PUSH, 346, 0, 1'b1);
    queue_event(CMD_PUSH, 0, 260, 1'b0);
    queue_event(CMD_READ, 511, 511, 1'b1);
    queue_event(CMD_PUSH, 511, 0, 1'b0);
    queue_event(CMD_READ, 100, 100, 1'b1);
    queue_event(CMD_READ, 0, 511, 1'b0);
    wait_drained();

    // Unknown index is ignored; window size zero acts as one
    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_write(REG_WIDTH, 15'd512);
    cfg_write(REG_HEIGHT, 15'd512);
    cfg_write(REG_WINDOW, 15'd0);
    queue_event(CMD_PUSH, 511, 511, 1'b1);
    queue_event(CMD_PUSH, 511, 511, 1'b0);
    queue_event(CMD_READ, 511, 511, 1'b0);
    queue_event(CMD_PUSH, 0, 0, 1'b1);
    queue_event(CMD_READ, 511, 511, 1'b1);
    queue_event(CMD_READ, 0, 0, 1'b0);
    wait_drained();

    // Smallest frame
    cfg_write(REG_WIDTH, 15'd1);
    cfg_write(REG_HEIGHT, 15'd1);
    queue_event(CMD_PUSH, 0, 0, 1'b0);
    queue_event(CMD_PUSH, 1, 0, 1'b1);
    queue_event(CMD_READ, 0, 1, 1'b0);
    queue_event(CMD_PUSH, 0, 0, 1'b1);
    wait_drained();

    // Zero width: everything lies outside
    cfg_write(REG_WIDTH, 15'd0);
    queue_event(CMD_PUSH, 0, 0, 1'b1);
    queue_event(CMD_READ, 0, 0, 1'b0);
    wait_drained();

    // All register bits set: bounds truncate to ten bits
    cfg_write(REG_WIDTH, 15'h7FFF);
    cfg_write(REG_HEIGHT, 15'h7FFF);
    queue_event(CMD_PUSH, 511, 511, 1'b1);
    queue_event(CMD_READ, 0, 0, 1'b1);
    queue_random(80, 500, 500);
    wait_drained();

    // Small window: evicted event now outside the frame still decrements its pixel
    cfg_write(REG_WINDOW, 15'd5);
    for (int i = 0; i < 5; i++) queue_event(CMD_PUSH, 400, 400, i[0]);
    wait_drained();
    cfg_write(REG_WIDTH, 15'd10);
    queue_event(CMD_PUSH, 1, 1, 1'b0);
    wait_drained();
    cfg_write(REG_WIDTH, 15'd512);
    queue_event(CMD_READ, 400, 400, 1'b0);
    wait_drained();

    // Bulk traffic with a full window, one chunk per frame setting
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: begin
          cfg_write(REG_HEIGHT, 15'd512);
          queue_random(90, 30, 40);
        end
        1: begin
          idle_pct = 0;
          cfg_write(REG_WIDTH, 15'(WIDTH_RESET));
          cfg_write(REG_HEIGHT, 15'(HEIGHT_RESET));
          queue_random(90, 343, 257);
        end
        2: begin
          idle_pct = 18;
          w = $urandom_range(512, 1);
          h = $urandom_range(512, 1);
          cfg_write(REG_WIDTH, 15'(w));
          cfg_write(REG_HEIGHT, 15'(h));
          queue_random(90, $urandom_range(w - 1), $urandom_range(h - 1));
        end
        default: begin
          cfg_write(REG_WIDTH, 15'd16);
          cfg_write(REG_HEIGHT, 15'd16);
          queue_random(90, 13, 14);
        end
      endcase
      wait_drained();
    end

    // Oversized window saturates to the full depth
    cfg_write(REG_WINDOW, 15'h7FFF);
    cfg_write(REG_WIDTH, 15'd512);
    cfg_write(REG_HEIGHT, 15'd512);
    queue_random(130, 200, 300);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("event_window_pixel_histogram_core: match");
    end else begin
      $display("event_window_pixel_histogram_core: mismatch");
    end
    $finish;
  end

endmodule

/* event_window_pixel_histogram_core.f */
+incdir+hdl
hdl/ewph_pkg.sv
hdl/ewph_ctrl.sv
hdl/ewph_datapath.sv
hdl/event_window_pixel_histogram_core.sv
tb/sv/tb_event_window_pixel_histogram_core.sv
